### design/psc_pkg.sv
// Package for the pressure sensor compensation block.
// Holds the sequencer state type, register indexes and fixed compensation constants.
// No dependencies.
package psc_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_OSS    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_AC1AC2 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_AC3AC4 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_AC5AC6 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_B1B2   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MCMD   = 3'd5;

  localparam logic ACT_TEMP  = 1'b0;
  localparam logic ACT_PRESS = 1'b1;

  localparam logic [31:0] C_B6_OFS   = 32'd4000;
  localparam logic [31:0] C_B4_OFS   = 32'd32768;
  localparam logic [31:0] C_B7_SCALE = 32'd50000;
  localparam logic [31:0] C_P_K1     = 32'd3038;
  localparam logic [31:0] C_P_K2     = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] C_P_K3     = 32'd3791;

  typedef enum logic [4:0] {
    S_IDLE,
    S_T0, S_T1, S_TFIN,
    S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7,
    S_DIV,
    S_P8, S_P9, S_P10,
    S_DONE
  } state_t;

endpackage

### design/pressure_sensor_compensation.sv
// Top level of the pressure sensor compensation block.
// Depends on psc_pkg; one shared multiplier and one serial divider under a sequencer.
//
// Usage:
//  - Input channel (in_valid/in_stall): in_action 0 carries a raw temperature in
//    bits 15..0 of in_raw_reading, 1 carries a raw 24-bit pressure word.
//  - Output channel (out_valid/out_stall): one result per item, out_kind echoes
//    the action, out_value is 0.1 degC or Pa, out_divide_error flags a zero divisor.
//  - Configuration: cfg_we/cfg_index/cfg_wdata write oversampling and the
//    calibration pairs; write only while no item is in flight.
//  - Timing: the 32-step restoring divider sets most of the time from transfer to
//    result register, and a zero divisor skips it; the rest is one multiply step
//    per cycle on the shared multiplier. Next transfer at the earliest in the cycle
//    after the result load.
//  - Throughput: one item at a time; in_stall is high from transfer until the
//    result is loaded into the output register.
//  - A stalled result holds in the output register; the sequencer waits in its
//    last step until that register is free.
//  - Reset clears the configuration, the stored B5 term and the output valid.
module pressure_sensor_compensation
  import psc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_action,
  input  logic [23:0]         in_raw_reading,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_kind,
  output logic signed [31:0]  out_value,
  output logic                out_divide_error,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [31:0]         cfg_wdata
);

  state_t state_r, state_nxt;

  logic [1:0]  oss_r;
  logic [31:0] ac12_r, ac34_r, ac56_r, b12_r, mcmd_r;
  logic [31:0] tt_r, tt_nxt;

  logic        kind_r, kind_nxt;
  logic [23:0] raw_r, raw_nxt;
  logic [31:0] x1_r, x1_nxt;
  logic [31:0] sq_r, sq_nxt;
  logic [31:0] b6_r, b6_nxt;
  logic [31:0] b3_r, b3_nxt;
  logic [31:0] t_r, t_nxt;
  logic [31:0] b4_r, b4_nxt;
  logic [31:0] b7_r, b7_nxt;
  logic [31:0] p_r, p_nxt;
  logic [31:0] dvd_r, dvd_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] val_r, val_nxt;
  logic        err_r, err_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_kind_nxt;
  logic [31:0] out_value_r, out_value_nxt;
  logic        out_err_r, out_err_nxt;

  logic [31:0] mul_a, mul_b, mul_p;
  logic [32:0] rem_sh, rem_sub;
  logic [31:0] p_q;

  // calibration fields
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {{16{ac12_r[31]}}, ac12_r[31:16]};
  assign ac2 = {{16{ac12_r[15]}}, ac12_r[15:0]};
  assign ac3 = {{16{ac34_r[31]}}, ac34_r[31:16]};
  assign ac4 = {16'd0, ac34_r[15:0]};
  assign ac5 = {16'd0, ac56_r[31:16]};
  assign ac6 = {16'd0, ac56_r[15:0]};
  assign b1  = {{16{b12_r[31]}}, b12_r[31:16]};
  assign b2  = {{16{b12_r[15]}}, b12_r[15:0]};
  assign mc  = {{16{mcmd_r[31]}}, mcmd_r[31:16]};
  assign md  = {{16{mcmd_r[15]}}, mcmd_r[15:0]};

  assign mul_p   = mul_a * mul_b;
  assign rem_sh  = {rem_r, dvd_r[31]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  // pressure before correction, straight from the divider quotient
  assign p_q = b7_r[31] ? (dvd_r << 1) : dvd_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oss_r  <= '0;
      ac12_r <= '0;
      ac34_r <= '0;
      ac56_r <= '0;
      b12_r  <= '0;
      mcmd_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OSS:    oss_r  <= cfg_wdata[1:0];
        REG_AC1AC2: ac12_r <= cfg_wdata;
        REG_AC3AC4: ac34_r <= cfg_wdata;
        REG_AC5AC6: ac56_r <= cfg_wdata;
        REG_B1B2:   b12_r  <= cfg_wdata;
        REG_MCMD:   mcmd_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tt_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tt_r        <= tt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    raw_r       <= raw_nxt;
    x1_r        <= x1_nxt;
    sq_r        <= sq_nxt;
    b6_r        <= b6_nxt;
    b3_r        <= b3_nxt;
    t_r         <= t_nxt;
    b4_r        <= b4_nxt;
    b7_r        <= b7_nxt;
    p_r         <= p_nxt;
    dvd_r       <= dvd_nxt;
    dvs_r       <= dvs_nxt;
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
    neg_r       <= neg_nxt;
    val_r       <= val_nxt;
    err_r       <= err_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_err_r   <= out_err_nxt;
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_T0:  begin mul_a = {16'd0, raw_r[15:0]} - ac6; mul_b = ac5; end
      S_P0:  begin mul_a = tt_r - C_B6_OFS; mul_b = tt_r - C_B6_OFS; end
      S_P1:  begin mul_a = b2; mul_b = sq_r; end
      S_P2:  begin mul_a = ac2; mul_b = b6_r; end
      S_P3:  begin mul_a = ac3; mul_b = b6_r; end
      S_P4:  begin mul_a = b1; mul_b = sq_r; end
      S_P5:  begin mul_a = ac4; mul_b = t_r + C_B4_OFS; end
      S_P6:  begin
        mul_a = (32'(raw_r) >> (4'd8 - {2'b00, oss_r})) - b3_r;
        mul_b = C_B7_SCALE >> oss_r;
      end
      S_P8:  begin
        mul_a = 32'($signed(p_q) >>> 8);
        mul_b = 32'($signed(p_q) >>> 8);
      end
      S_P9:  begin mul_a = x1_r; mul_b = C_P_K1; end
      S_P10: begin mul_a = C_P_K2; mul_b = p_r; end
      default: ;
    endcase
  end

  always_comb begin
    logic [31:0] den, num, tmp, q, b5;
    state_nxt     = state_r;
    tt_nxt        = tt_r;
    kind_nxt      = kind_r;
    raw_nxt       = raw_r;
    x1_nxt        = x1_r;
    sq_nxt        = sq_r;
    b6_nxt        = b6_r;
    b3_nxt        = b3_r;
    t_nxt         = t_r;
    b4_nxt        = b4_r;
    b7_nxt        = b7_r;
    p_nxt         = p_r;
    dvd_nxt       = dvd_r;
    dvs_nxt       = dvs_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    val_nxt       = val_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_err_nxt   = out_err_r;
    den = x1_r + md;
    num = mc << 11;
    tmp = '0;
    q   = '0;
    b5  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_action;
          raw_nxt   = in_raw_reading;
          err_nxt   = 1'b0;
          val_nxt   = '0;
          state_nxt = (in_action == ACT_PRESS) ? S_P0 : S_T0;
        end
      end
      S_T0: begin
        x1_nxt    = 32'($signed(mul_p) >>> 15);
        state_nxt = S_T1;
      end
      S_T1: begin
        if (den == '0) begin
          err_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          neg_nxt   = num[31] ^ den[31];
          dvd_nxt   = num[31] ? -num : num;
          dvs_nxt   = den[31] ? -den : den;
          rem_nxt   = '0;
          cnt_nxt   = '1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!rem_sub[32]) begin
          rem_nxt = rem_sub[31:0];
          dvd_nxt = {dvd_r[30:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[31:0];
          dvd_nxt = {dvd_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == '0) begin
          state_nxt = (kind_r == ACT_PRESS) ? S_P8 : S_TFIN;
        end
      end
      S_TFIN: begin
        q         = neg_r ? -dvd_r : dvd_r;
        b5        = x1_r + q;
        tt_nxt    = b5;
        val_nxt   = 32'($signed(b5 + 32'd8) >>> 4);
        state_nxt = S_DONE;
      end
      S_P0: begin
        b6_nxt    = tt_r - C_B6_OFS;
        sq_nxt    = 32'($signed(mul_p) >>> 12);
        state_nxt = S_P1;
      end
      S_P1: begin
        t_nxt     = 32'($signed(mul_p) >>> 11);
        state_nxt = S_P2;
      end
      S_P2: begin
        tmp       = t_r + 32'($signed(mul_p) >>> 11);
        tmp       = ((ac1 << 2) + tmp) << oss_r;
        b3_nxt    = 32'($signed(tmp + 32'd2) >>> 2);
        state_nxt = S_P3;
      end
      S_P3: begin
        t_nxt     = 32'($signed(mul_p) >>> 13);
        state_nxt = S_P4;
      end
      S_P4: begin
        tmp       = t_r + 32'($signed(mul_p) >>> 16) + 32'd2;
        t_nxt     = 32'($signed(tmp) >>> 2);
        state_nxt = S_P5;
      end
      S_P5: begin
        b4_nxt    = mul_p >> 15;
        state_nxt = S_P6;
      end
      S_P6: begin
        b7_nxt    = mul_p;
        state_nxt = S_P7;
      end
      S_P7: begin
        if (b4_r == '0) begin
          err_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          dvd_nxt   = b7_r[31] ? b7_r : (b7_r << 1);
          dvs_nxt   = b4_r;
          rem_nxt   = '0;
          cnt_nxt   = '1;
          state_nxt = S_DIV;
        end
      end
      S_P8: begin
        p_nxt     = p_q;
        state_nxt = S_P9;
      end
      S_P9: begin
        // x1 was squared in the step before; scale it now
        state_nxt = S_P10;
      end
      S_P10: begin
        tmp       = x1_r + 32'($signed(mul_p) >>> 16) + C_P_K3;
        val_nxt   = p_r + 32'($signed(tmp) >>> 4);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_value_nxt = val_r;
          out_err_nxt   = err_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // P8 squares p, P9 scales the square; both land in x1
    if (state_r == S_P8) begin
      x1_nxt = mul_p;
    end
    if (state_r == S_P9) begin
      x1_nxt = 32'($signed(mul_p) >>> 16);
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_value        = out_value_r;
  assign out_divide_error = out_err_r;

endmodule

### bench/pressure_sensor_compensation_test.sv
// Testbench for pressure_sensor_compensation: drives raw readings and calibration,
// predicts every result and checks it field by field. Depends on psc_pkg and the RTL.
`timescale 1ns / 100ps

module pressure_sensor_compensation_test;
  import psc_pkg::*;

  typedef struct {
    logic        kind;
    logic [31:0] value;
    logic        div_err;
  } reading_t;

  class compensation_board;
    logic [31:0] regs [6];
    logic [31:0] b5_term;
    reading_t    pending[$];
    int          mismatches;
    int          n_temp, n_press, n_err;

    function new();
      foreach (regs[i]) regs[i] = '0;
      b5_term = '0;
      mismatches = 0;
      n_temp = 0;
      n_press = 0;
      n_err = 0;
    endfunction

    function logic [31:0] sx16(logic [15:0] v);
      return {{16{v[15]}}, v};
    endfunction

    function logic [31:0] asr(logic [31:0] v, int n);
      return $unsigned($signed(v) >>> n);
    endfunction

    function void note_reading(logic act, logic [23:0] raw);
      reading_t    r;
      logic [31:0] ut, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      logic [31:0] x1, x2, x3, den, up, b3, b4, b6, b7, sq, p, prod;
      longint      quo;
      int          oss;
      r.kind = act;
      r.value = '0;
      r.div_err = 1'b0;
      oss = regs[REG_OSS][1:0];
      if (act == ACT_TEMP) begin
        n_temp++;
        ut  = {16'd0, raw[15:0]};
        ac5 = {16'd0, regs[REG_AC5AC6][31:16]};
        ac6 = {16'd0, regs[REG_AC5AC6][15:0]};
        mc  = sx16(regs[REG_MCMD][31:16]);
        md  = sx16(regs[REG_MCMD][15:0]);
        prod = (ut - ac6) * ac5;
        x1 = asr(prod, 15);
        den = x1 + md;
        if (den == 0) begin
          r.div_err = 1'b1;
        end else begin
          quo = longint'($signed(mc << 11)) / longint'($signed(den));
          x2 = quo[31:0];
          b5_term = x1 + x2;
          r.value = asr(b5_term + 32'd8, 4);
        end
      end else begin
        n_press++;
        ac1 = sx16(regs[REG_AC1AC2][31:16]);
        ac2 = sx16(regs[REG_AC1AC2][15:0]);
        ac3 = sx16(regs[REG_AC3AC4][31:16]);
        ac4 = {16'd0, regs[REG_AC3AC4][15:0]};
        b1  = sx16(regs[REG_B1B2][31:16]);
        b2  = sx16(regs[REG_B1B2][15:0]);
        up  = {8'd0, raw} >> (8 - oss);
        b6  = b5_term - C_B6_OFS;
        prod = b6 * b6;
        sq = asr(prod, 12);
        prod = b2 * sq;
        x1 = asr(prod, 11);
        prod = ac2 * b6;
        x2 = asr(prod, 11);
        x3 = x1 + x2;
        b3 = asr((((ac1 << 2) + x3) << oss) + 32'd2, 2);
        prod = ac3 * b6;
        x1 = asr(prod, 13);
        prod = b1 * sq;
        x2 = asr(prod, 16);
        x3 = asr(x1 + x2 + 32'd2, 2);
        prod = ac4 * (x3 + C_B4_OFS);
        b4 = prod >> 15;
        b7 = (up - b3) * (C_B7_SCALE >> oss);
        if (b4 == 0) begin
          r.div_err = 1'b1;
        end else begin
          if (b7 < 32'h8000_0000) p = (b7 << 1) / b4;
          else p = (b7 / b4) << 1;
          x1 = asr(p, 8) * asr(p, 8);
          prod = x1 * C_P_K1;
          x1 = asr(prod, 16);
          prod = C_P_K2 * p;
          x2 = asr(prod, 16);
          p = p + asr(x1 + x2 + C_P_K3, 4);
          r.value = p;
        end
      end
      if (r.div_err) n_err++;
      pending.push_back(r);
    endfunction

    function void check_result(logic kind, logic [31:0] value, logic div_err);
      reading_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result kind=%0d value=%0d", kind, value);
        return;
      end
      e = pending.pop_front();
      if (kind !== e.kind || value !== e.value || div_err !== e.div_err) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t: expected kind=%0d value=%0d err=%0d, got %0d %0d %0d",
                   $realtime, e.kind, $signed(e.value), e.div_err, kind, $signed(value),
                   div_err);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_action = 1'b0;
  logic [23:0]         in_raw_reading = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_kind;
  logic signed [31:0]  out_value;
  logic                out_divide_error;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [31:0]         cfg_wdata = '0;

  compensation_board board = new();
  bit idle_on = 1'b1;
  int stall_left = 0;

  pressure_sensor_compensation i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_kind, out_value, out_divide_error);
  end

  always @(posedge clk) begin
    int n;
    n = stall_left;
    if (n == 0 && idle_on && $urandom_range(0, 5) == 0) n = $urandom_range(1, 4);
    out_stall <= (n != 0);
    stall_left <= (n != 0) ? n - 1 : 0;
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.regs[idx] = (idx == REG_OSS) ? {30'd0, data[1:0]} : data;
  endtask

  // Drop valid so the last item is not taken twice, then wait for all results.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Hold the item until a transfer, then maybe drop valid for a short gap.
  task automatic send_reading(logic act, logic [23:0] raw);
    in_valid <= 1'b1;
    in_action <= act;
    in_raw_reading <= raw;
    do @(posedge clk); while (in_stall);
    board.note_reading(act, raw);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic load_cal(logic [31:0] oss, logic [31:0] a12, logic [31:0] a34,
                          logic [31:0] a56, logic [31:0] bb, logic [31:0] mm);
    drain();
    write_reg(REG_OSS, oss);
    write_reg(REG_AC1AC2, a12);
    write_reg(REG_AC3AC4, a34);
    write_reg(REG_AC5AC6, a56);
    write_reg(REG_B1B2, bb);
    write_reg(REG_MCMD, mm);
  endtask

  function automatic logic [15:0] jitter(logic [15:0] v, int span);
    return v + 16'($urandom_range(0, 2 * span)) - 16'(span);
  endfunction

  task automatic random_phase(int items);
    logic [23:0] raw;
    logic        act;
    repeat (items) begin
      act = ($urandom_range(0, 9) < 4) ? ACT_TEMP : ACT_PRESS;
      case ($urandom_range(0, 2))
        0: raw = 24'($urandom);
        1: raw = act == ACT_TEMP ? {8'($urandom), jitter(16'd27898, 3000)}
                                 : {jitter(16'd23843, 4000), 8'($urandom)};
        default: raw = act == ACT_TEMP ? {8'($urandom), 16'($urandom)}
                                       : 24'($urandom_range(0, 255)) << $urandom_range(0, 16);
      endcase
      send_reading(act, raw);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset calibration: both divisors are zero, pressure before any temperature.
    send_reading(ACT_PRESS, 24'h5D_2300);
    send_reading(ACT_TEMP, 24'h00_6CFA);
    send_reading(ACT_PRESS, 24'hFF_FFFF);

    // Datasheet coefficients and readings, then field extremes.
    load_cal(32'd0, {16'd408, 16'hFFB8}, {16'hC7D1, 16'd32741}, {16'd32757, 16'd23153},
             {16'd6190, 16'd4}, {16'hDDF9, 16'd2868});
    send_reading(ACT_TEMP, 24'h00_6CFA);
    send_reading(ACT_PRESS, 24'h5D_2300);
    send_reading(ACT_TEMP, 24'hFF_6CFA);
    send_reading(ACT_TEMP, 24'h00_0000);
    send_reading(ACT_TEMP, 24'hFF_FFFF);
    send_reading(ACT_PRESS, 24'h00_0000);
    send_reading(ACT_PRESS, 24'hFF_FFFF);
    send_reading(ACT_TEMP, 24'h00_6CFA);
    // Temperature divide by zero keeps the stored term: MD cancels X1.
    load_cal(32'd3, {16'd408, 16'hFFB8}, {16'hC7D1, 16'd32741}, {16'd32768, 16'd0},
             {16'd6190, 16'd4}, {16'hDDF9, 16'hFFFF});
    send_reading(ACT_TEMP, 24'h00_0001);
    send_reading(ACT_PRESS, 24'h5D_2300);
    send_reading(ACT_PRESS, 24'hFF_FFFF);
    // All ones everywhere except MC, which is negative-most for the most negative numerator.
    load_cal(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF, {16'h8000, 16'hFFFF});
    send_reading(ACT_TEMP, 24'hFF_FFFF);
    send_reading(ACT_TEMP, 24'h00_0000);
    send_reading(ACT_PRESS, 24'hFF_FFFF);
    send_reading(ACT_PRESS, 24'h00_0000);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) idle_on = 1'b0;
      case (ph % 4)
        0, 1: load_cal(32'($urandom_range(0, 3)),
                       {jitter(16'd408, 300), jitter(16'hFFB8, 300)},
                       {jitter(16'hC7D1, 2000), jitter(16'd32741, 2000)},
                       {jitter(16'd32757, 2000), jitter(16'd23153, 2000)},
                       {jitter(16'd6190, 500), jitter(16'd4, 4)},
                       {jitter(16'hDDF9, 500), jitter(16'd2868, 500)});
        2: load_cal($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        default: load_cal(32'(ph[1] ? 3 : 0), $urandom, {16'($urandom), 16'd0},
                          $urandom, $urandom, $urandom);
      endcase
      random_phase(180);
    end
    in_valid <= 1'b0;
    drain();
    $display("covered %0d temperature and %0d pressure readings, %0d divide errors",
             board.n_temp, board.n_press, board.n_err);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule

### files.f
design/psc_pkg.sv
design/pressure_sensor_compensation.sv
bench/pressure_sensor_compensation_test.sv
